FILE: sv/rssi_pulse_width_capture_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the radio burst capture engine
// Implication checks on the rising clock edge, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef RSSI_PULSE_WIDTH_CAPTURE_CORE_ASSERT_SVH
`define RSSI_PULSE_WIDTH_CAPTURE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define RPWC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rpwc check failed");
`define RPWC_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rpwc check failed");
`else
`define RPWC_ASSERT_IMP(lbl, ante, cons)
`define RPWC_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

FILE: sv/rpwc_pkg.sv
// ----------------------------------------------------------------------------
// rpwc_pkg
// Types, codes and constants shared by the capture engine modules.
// ----------------------------------------------------------------------------
package rpwc_pkg;

	localparam int RPWC_CAPACITY = 1024;

	typedef enum logic [2:0] {
		ST_IDLE    = 3'd0,
		ST_WAIT    = 3'd1,
		ST_CAPT    = 3'd2,
		ST_DONE    = 3'd3,
		ST_TIMEOUT = 3'd4,
		ST_LONG    = 3'd5,
		ST_CANCEL  = 3'd6,
		ST_FAIL    = 3'd7
	} capture_state_t;

	typedef enum logic [3:0] {
		FN_START  = 4'd0,
		FN_SAMPLE = 4'd1,
		FN_ARM    = 4'd2,
		FN_EDGE   = 4'd3,
		FN_XEND   = 4'd4,
		FN_CANCEL = 4'd5,
		FN_FAIL   = 4'd6,
		FN_READ   = 4'd7,
		FN_TICK   = 4'd8,
		FN_CLEAR  = 4'd9
	} func_t;

	typedef enum logic [2:0] {
		REG_THR     = 3'd0,
		REG_DEB     = 3'd1,
		REG_WAIT    = 3'd2,
		REG_LONG    = 3'd3,
		REG_GAP     = 3'd4,
		REG_MAXP    = 3'd5,
		REG_MINEDGE = 3'd6,
		REG_EDGE    = 3'd7
	} reg_idx_t;

	localparam logic signed [7:0] RSSI_MIN = -8'sd127;
	localparam logic signed [7:0] RSSI_MAX = 8'sd0;
	localparam logic signed [7:0] THR_MIN  = -8'sd110;
	localparam logic signed [7:0] THR_MAX  = -8'sd30;
	localparam logic signed [7:0] THR_RST  = -8'sd90;
	localparam logic [15:0] SAT16     = 16'hFFFF;
	localparam logic [9:0]  US_PER_MS = 10'd1000;
	localparam logic [31:0] CNT_MAX   = 32'hFFFF_FFFF;

	typedef struct packed {
		logic           rd;
		logic           accepted;
		capture_state_t state;
		logic [10:0]    count;
		logic           trunc;
		logic [31:0]    sample_total;
		logic [31:0]    invalid_total;
		logic [31:0]    short_total;
		logic [63:0]    signal_start;
		logic [63:0]    end_time;
		logic           first_level;
		logic [31:0]    error_code;
	} res_t;

	function automatic logic [31:0] sat_inc(input logic [31:0] v);
		return (v == CNT_MAX) ? v : v + 32'd1;
	endfunction

endpackage

FILE: sv/rssi_pulse_width_capture_core.sv
// ----------------------------------------------------------------------------
// rssi_pulse_width_capture_core
// Radio burst capture engine: debounced carrier levels into pulse lengths.
// ----------------------------------------------------------------------------
// Usage:
//  Commands enter on the slave stream; s_tuser carries the command code and
//  s_tdata its arguments. Every command item yields exactly one status item
//  on the master stream, in order.
//  Configuration is written through cfg_wen/cfg_index/cfg_wdata while no
//  item is in flight; the start command copies it into the working plan.
//  Throughput: one item per cycle while the receiver keeps up. Each item passes
//  the pipeline stage (state update and pulse memory access), then the
//  output register that drives m_tvalid; the pulse memory read is registered.
//  Reset returns the engine to idle with all counters cleared and the
//  registers at their defaults; the pulse memory needs no clearing pass.
//  When the receiver stalls, one item waits in the output register and one
//  in the pipeline stage; s_tready falls once both are held.
// ----------------------------------------------------------------------------
`include "rssi_pulse_width_capture_core_assert.svh"
module rssi_pulse_width_capture_core import rpwc_pkg::*; #(
	parameter int PULSE_CAPACITY = RPWC_CAPACITY
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_wen,
	input  logic [2:0]   cfg_index,
	input  logic [18:0]  cfg_wdata,
	input  logic         s_tvalid,
	output logic         s_tready,
	// time_us[63:0], rssi_dbm[71:64], new_level[72], pulse_length_us[104:73],
	// clip_flag[105], overflow_flag[106], error_code_in[138:107], pulse_index[148:139]
	input  logic [151:0] s_tdata,
	// func[3:0]
	input  logic [3:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// accepted[0], capture_state[3:1], pulse_count[14:4], pulse_value[30:15],
	// truncated[31], sample_total[63:32], invalid_total[95:64],
	// short_total[127:96], signal_start_us[191:128], end_time_us[255:192],
	// first_level[256], error_code_out[288:257]
	output logic [295:0] m_tdata
);

	localparam int AW = $clog2(PULSE_CAPACITY);

	logic          take, adv;
	logic          mem_we, mem_re;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [15:0]   mem_wdata, rdata;
	res_t          res, res_s1;
	logic          v_s1, out_v_q;
	logic [295:0]  out_q;

	assign adv      = v_s1 && (!out_v_q || m_tready);
	assign s_tready = !v_s1 || !out_v_q || m_tready;
	assign take     = s_tvalid && s_tready;

	rpwc_ctrl #(.PULSE_CAPACITY(PULSE_CAPACITY)) u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.take(take), .func(s_tuser), .t(s_tdata[63:0]), .rssi(s_tdata[71:64]),
		.new_level(s_tdata[72]), .dur(s_tdata[104:73]), .clip(s_tdata[105]),
		.ovf(s_tdata[106]), .ecode(s_tdata[138:107]), .idx(s_tdata[148:139]),
		.mem_we(mem_we), .mem_waddr(mem_waddr), .mem_wdata(mem_wdata),
		.mem_re(mem_re), .mem_raddr(mem_raddr), .res(res)
	);

	rpwc_store #(.PULSE_CAPACITY(PULSE_CAPACITY)) u_store (
		.clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
		.re(mem_re), .raddr(mem_raddr), .rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (take) begin
				v_s1 <= 1'b1;
			end else if (adv) begin
				v_s1 <= 1'b0;
			end
			if (adv) begin
				out_v_q <= 1'b1;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_s1 <= res;
		end
		if (adv) begin
			out_q <= {7'd0, res_s1.error_code, res_s1.first_level, res_s1.end_time,
				res_s1.signal_start, res_s1.short_total, res_s1.invalid_total,
				res_s1.sample_total, res_s1.trunc, (res_s1.rd ? rdata : 16'd0),
				res_s1.count, res_s1.state, res_s1.accepted};
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_q;

	`RPWC_ASSERT_IMP(a_hold_input, v_s1 && out_v_q && !m_tready, !s_tready)
	`RPWC_ASSERT_IMP(a_idle_empty, v_s1 && res_s1.state == ST_IDLE, res_s1.count == 11'd0)
	`RPWC_ASSERT_NXT(a_stage_fill, take, v_s1)

endmodule

FILE: sv/rpwc_store.sv
// ----------------------------------------------------------------------------
// rpwc_store
// Pulse length memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module rpwc_store import rpwc_pkg::*; #(
	parameter int PULSE_CAPACITY = RPWC_CAPACITY
) (
	input  logic                              clk,
	input  logic                              we,
	input  logic [$clog2(PULSE_CAPACITY)-1:0] waddr,
	input  logic [15:0]                       wdata,
	input  logic                              re,
	input  logic [$clog2(PULSE_CAPACITY)-1:0] raddr,
	output logic [15:0]                       rdata
);

	logic [15:0] mem_q [PULSE_CAPACITY];
	logic [15:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: sv/rpwc_ctrl.sv
// ----------------------------------------------------------------------------
// rpwc_ctrl
// Configuration registers, capture state and per-item update logic.
// ----------------------------------------------------------------------------
module rpwc_ctrl import rpwc_pkg::*; #(
	parameter int PULSE_CAPACITY = RPWC_CAPACITY
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wen,
	input  logic [2:0]                        cfg_index,
	input  logic [18:0]                       cfg_wdata,
	input  logic                              take,
	input  logic [3:0]                        func,
	input  logic [63:0]                       t,
	input  logic signed [7:0]                 rssi,
	input  logic                              new_level,
	input  logic [31:0]                       dur,
	input  logic                              clip,
	input  logic                              ovf,
	input  logic [31:0]                       ecode,
	input  logic [9:0]                        idx,
	output logic                              mem_we,
	output logic [$clog2(PULSE_CAPACITY)-1:0] mem_waddr,
	output logic [15:0]                       mem_wdata,
	output logic                              mem_re,
	output logic [$clog2(PULSE_CAPACITY)-1:0] mem_raddr,
	output res_t                              res
);

	localparam int AW = $clog2(PULSE_CAPACITY);
	localparam int CW = $clog2(PULSE_CAPACITY + 1);

	// configuration
	logic signed [7:0] r_thr_q;
	logic [9:0]  r_deb_q, r_minedge_q;
	logic [18:0] r_wait_q;
	logic [15:0] r_long_q, r_gap_q;
	logic [10:0] r_maxp_q;
	logic        r_edge_q;

	// working plan
	logic signed [7:0] p_thr_q, n_p_thr;
	logic [9:0]  p_deb_q, n_p_deb, p_minedge_q, n_p_minedge;
	logic [28:0] p_wait_us_q, n_p_wait_us;
	logic [25:0] p_long_us_q, n_p_long_us;
	logic [15:0] p_gap_q, n_p_gap;
	logic [10:0] p_maxp_q, n_p_maxp;
	logic        p_edge_q, n_p_edge;

	capture_state_t ph_q, n_ph;
	logic [63:0] start_q, n_start, sig_q, n_sig, end_q, n_end;
	logic [63:0] cand_since_q, n_cand_since, stab_since_q, n_stab_since;
	logic [63:0] last_q, n_last;
	logic [CW-1:0] cnt_q, n_cnt;
	logic cand_v_q, n_cand_v, cand_l_q, n_cand_l, stab_l_q, n_stab_l;
	logic edge_l_q, n_edge_l, edge_v_q, n_edge_v;
	logic trunc_q, n_trunc, first_q, n_first;
	logic [31:0] c0_q, n_c0, c1_q, n_c1, c2_q, n_c2, err_q, n_err;

	logic plan_ok;

	function automatic logic at_limit(input logic [CW-1:0] c, input logic [10:0] mp);
		return (32'(c) >= 32'(mp)) || (32'(c) >= 32'(PULSE_CAPACITY));
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_thr_q     <= THR_RST;
			r_deb_q     <= 10'd100;
			r_wait_q    <= 19'd30000;
			r_long_q    <= 16'd10000;
			r_gap_q     <= 16'd20000;
			r_maxp_q    <= 11'd1024;
			r_minedge_q <= 10'd50;
			r_edge_q    <= 1'b0;
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_THR:     r_thr_q     <= cfg_wdata[7:0];
				REG_DEB:     r_deb_q     <= cfg_wdata[9:0];
				REG_WAIT:    r_wait_q    <= cfg_wdata;
				REG_LONG:    r_long_q    <= cfg_wdata[15:0];
				REG_GAP:     r_gap_q     <= cfg_wdata[15:0];
				REG_MAXP:    r_maxp_q    <= cfg_wdata[10:0];
				REG_MINEDGE: r_minedge_q <= cfg_wdata[9:0];
				REG_EDGE:    r_edge_q    <= cfg_wdata[0];
				default:     r_edge_q    <= r_edge_q;
			endcase
		end
	end

	assign plan_ok = (r_thr_q >= THR_MIN) && (r_thr_q <= THR_MAX) &&
		(r_deb_q >= 10'd20) && (r_deb_q <= 10'd1000) &&
		(r_wait_q >= 19'd1000) && (r_wait_q <= 19'd300000) &&
		(r_long_q >= 16'd100) && (r_long_q <= 16'd60000) &&
		(r_gap_q >= 16'd5000) && (r_gap_q <= 16'd60000) &&
		(r_maxp_q >= 11'd2) && (32'(r_maxp_q) <= 32'(PULSE_CAPACITY)) &&
		(r_minedge_q >= 10'd1) && (r_minedge_q <= 10'd1000);

	always_comb begin
		logic        acc, lvl, do_svc, svc;
		logic [63:0] d;
		logic        csat;
		acc = 1'b0; do_svc = 1'b0; svc = 1'b0; lvl = 1'b0; d = '0; csat = 1'b0;
		n_p_thr = p_thr_q; n_p_deb = p_deb_q; n_p_minedge = p_minedge_q;
		n_p_wait_us = p_wait_us_q; n_p_long_us = p_long_us_q; n_p_gap = p_gap_q;
		n_p_maxp = p_maxp_q; n_p_edge = p_edge_q;
		n_ph = ph_q; n_start = start_q; n_sig = sig_q; n_end = end_q;
		n_cand_since = cand_since_q; n_stab_since = stab_since_q; n_last = last_q;
		n_cnt = cnt_q; n_cand_v = cand_v_q; n_cand_l = cand_l_q; n_stab_l = stab_l_q;
		n_edge_l = edge_l_q; n_edge_v = edge_v_q; n_trunc = trunc_q; n_first = first_q;
		n_c0 = c0_q; n_c1 = c1_q; n_c2 = c2_q; n_err = err_q;
		mem_we = 1'b0; mem_waddr = cnt_q[AW-1:0]; mem_wdata = '0;
		mem_re = 1'b0; mem_raddr = AW'(idx);
		if (take) begin
			case (func)
				FN_START: begin
					if (ph_q == ST_IDLE && t != '0 && plan_ok) begin
						n_p_thr = r_thr_q; n_p_deb = r_deb_q; n_p_minedge = r_minedge_q;
						n_p_wait_us = 29'(r_wait_q * US_PER_MS);
						n_p_long_us = 26'(r_long_q * US_PER_MS);
						n_p_gap = r_gap_q; n_p_maxp = r_maxp_q; n_p_edge = r_edge_q;
						n_c0 = '0; n_c1 = '0; n_c2 = '0;
						n_trunc = 1'b0; n_first = 1'b0; n_err = '0;
						n_sig = '0; n_end = '0; n_ph = ST_WAIT; n_start = t; n_cnt = '0;
						n_cand_v = 1'b0; n_cand_since = '0; n_stab_since = '0; n_last = '0;
						n_edge_l = 1'b0; n_edge_v = 1'b0;
						acc = 1'b1;
					end
				end
				FN_SAMPLE: begin
					if (ph_q == ST_WAIT || ph_q == ST_CAPT) begin
						n_c0 = sat_inc(c0_q);
						if (t == '0 || t < start_q || t < last_q ||
							rssi < RSSI_MIN || rssi > RSSI_MAX) begin
							n_c1 = sat_inc(c1_q);
						end else begin
							n_last = t;
							lvl = rssi > p_thr_q;
							do_svc = 1'b1;
							if (!cand_v_q || lvl != cand_l_q) begin
								if (cand_v_q && (t - cand_since_q) < 64'(p_deb_q)) begin
									n_c2 = sat_inc(c2_q);
								end
								n_cand_v = 1'b1; n_cand_l = lvl; n_cand_since = t;
							end else if ((t - cand_since_q) >= 64'(p_deb_q) &&
								(ph_q == ST_WAIT || cand_l_q != stab_l_q)) begin
								if (ph_q == ST_WAIT) begin
									if (cand_l_q) begin
										n_ph = ST_CAPT; n_sig = cand_since_q; n_first = 1'b1;
										n_stab_l = 1'b1; n_stab_since = cand_since_q;
										acc = 1'b1;
									end
								end else if (t >= stab_since_q) begin
									if (p_edge_q) begin
										n_stab_l = cand_l_q; n_stab_since = cand_since_q;
										acc = 1'b1;
									end else begin
										d = cand_since_q - stab_since_q;
										if (d != '0) begin
											if (at_limit(cnt_q, p_maxp_q)) begin
												if (cand_since_q >= sig_q) begin
													n_ph = ST_DONE; n_end = cand_since_q;
													n_trunc = 1'b1; acc = 1'b1;
												end
											end else begin
												csat = d > 64'(SAT16);
												if (csat) n_trunc = 1'b1;
												mem_we = 1'b1;
												mem_wdata = csat ? SAT16 : d[15:0];
												n_cnt = cnt_q + 1'b1;
												n_stab_l = cand_l_q; n_stab_since = cand_since_q;
												if (at_limit(cnt_q + 1'b1, p_maxp_q)) begin
													if (cand_since_q >= sig_q) begin
														n_ph = ST_DONE; n_end = cand_since_q;
														n_trunc = 1'b1; acc = 1'b1;
													end
												end else begin
													acc = 1'b1;
												end
											end
										end
									end
								end
							end
						end
					end
				end
				FN_ARM: begin
					if (p_edge_q && ph_q == ST_CAPT && t >= sig_q) begin
						if (!edge_v_q) n_first = new_level;
						n_edge_l = new_level; n_edge_v = 1'b1; acc = 1'b1;
					end
				end
				FN_EDGE: begin
					if (!p_edge_q || ph_q != ST_CAPT || !edge_v_q || t < sig_q || dur == '0) begin
						n_c1 = sat_inc(c1_q);
					end else if (new_level != edge_l_q) begin
						if (dur < 32'(p_minedge_q)) begin
							n_c2 = sat_inc(c2_q);
						end else if (at_limit(cnt_q, p_maxp_q)) begin
							n_ph = ST_DONE; n_end = t; n_trunc = 1'b1; acc = 1'b1;
						end else begin
							csat = clip || dur > 32'(SAT16);
							mem_we = 1'b1;
							mem_wdata = csat ? SAT16 : dur[15:0];
							if (csat) n_trunc = 1'b1;
							n_edge_l = new_level;
							n_cnt = cnt_q + 1'b1;
							if (at_limit(cnt_q + 1'b1, p_maxp_q)) begin
								n_ph = ST_DONE; n_end = t; n_trunc = 1'b1;
							end
							acc = 1'b1;
						end
					end
				end
				FN_XEND: begin
					if (p_edge_q && ph_q == ST_CAPT && t >= sig_q && ovf) begin
						n_ph = ST_DONE; n_end = t; n_trunc = 1'b1; acc = 1'b1;
					end
				end
				FN_CANCEL, FN_FAIL: begin
					if ((ph_q == ST_WAIT || ph_q == ST_CAPT) && t >= start_q) begin
						n_ph = (func == FN_CANCEL) ? ST_CANCEL : ST_FAIL;
						n_end = t;
						if (func == FN_FAIL) n_err = ecode;
						acc = 1'b1;
					end
				end
				FN_READ: begin
					if (32'(idx) < 32'(cnt_q)) begin
						mem_re = 1'b1; acc = 1'b1;
					end
				end
				FN_TICK: do_svc = 1'b1;
				FN_CLEAR: begin
					n_ph = ST_IDLE; n_start = '0; n_sig = '0; n_end = '0; n_cnt = '0;
					n_cand_v = 1'b0; n_cand_l = 1'b0; n_cand_since = '0;
					n_stab_l = 1'b0; n_stab_since = '0; n_last = '0;
					n_edge_l = 1'b0; n_edge_v = 1'b0;
					n_c0 = '0; n_c1 = '0; n_c2 = '0;
					n_trunc = 1'b0; n_first = 1'b0; n_err = '0;
					n_p_thr = '0; n_p_deb = '0; n_p_minedge = '0; n_p_wait_us = '0;
					n_p_long_us = '0; n_p_gap = '0; n_p_maxp = '0; n_p_edge = 1'b0;
					acc = 1'b1;
				end
				default: acc = 1'b0;
			endcase
			if (do_svc && t != '0 && t >= n_start) begin
				if (n_ph == ST_WAIT && (t - n_start) >= 64'(n_p_wait_us)) begin
					n_ph = ST_TIMEOUT; n_end = t; svc = 1'b1;
				end else if (n_ph == ST_CAPT && !n_stab_l &&
					(t - n_stab_since) >= 64'(n_p_gap)) begin
					if (n_p_edge && n_cnt == '0) begin
						n_ph = ST_TIMEOUT; n_end = t; svc = 1'b1;
					end else if (t >= n_sig) begin
						n_ph = ST_DONE; n_end = t; svc = 1'b1;
					end
				end else if (n_ph == ST_CAPT && (t - n_sig) >= 64'(n_p_long_us)) begin
					n_ph = ST_LONG; n_end = t; svc = 1'b1;
				end
			end
		end
		res.rd            = mem_re;
		res.accepted      = acc || svc;
		res.state         = n_ph;
		res.count         = 11'(n_cnt);
		res.trunc         = n_trunc;
		res.sample_total  = n_c0;
		res.invalid_total = n_c1;
		res.short_total   = n_c2;
		res.signal_start  = n_sig;
		res.end_time      = n_end;
		res.first_level   = n_first;
		res.error_code    = n_err;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_thr_q <= '0; p_deb_q <= '0; p_minedge_q <= '0; p_wait_us_q <= '0;
			p_long_us_q <= '0; p_gap_q <= '0; p_maxp_q <= '0; p_edge_q <= 1'b0;
			ph_q <= ST_IDLE; start_q <= '0; sig_q <= '0; end_q <= '0;
			cand_since_q <= '0; stab_since_q <= '0; last_q <= '0; cnt_q <= '0;
			cand_v_q <= 1'b0; cand_l_q <= 1'b0; stab_l_q <= 1'b0;
			edge_l_q <= 1'b0; edge_v_q <= 1'b0; trunc_q <= 1'b0; first_q <= 1'b0;
			c0_q <= '0; c1_q <= '0; c2_q <= '0; err_q <= '0;
		end else if (take) begin
			p_thr_q <= n_p_thr; p_deb_q <= n_p_deb; p_minedge_q <= n_p_minedge;
			p_wait_us_q <= n_p_wait_us; p_long_us_q <= n_p_long_us; p_gap_q <= n_p_gap;
			p_maxp_q <= n_p_maxp; p_edge_q <= n_p_edge;
			ph_q <= n_ph; start_q <= n_start; sig_q <= n_sig; end_q <= n_end;
			cand_since_q <= n_cand_since; stab_since_q <= n_stab_since; last_q <= n_last;
			cnt_q <= n_cnt; cand_v_q <= n_cand_v; cand_l_q <= n_cand_l; stab_l_q <= n_stab_l;
			edge_l_q <= n_edge_l; edge_v_q <= n_edge_v; trunc_q <= n_trunc;
			first_q <= n_first; c0_q <= n_c0; c1_q <= n_c1; c2_q <= n_c2; err_q <= n_err;
		end
	end

endmodule

FILE: sim/tb_rssi_pulse_width_capture_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rssi_pulse_width_capture_core
// Drives capture sessions through the command stream: start, samples at rising
// timestamps, edge events, limits, reads, cancel, fail and clear. Every status
// item is compared with a behavioural copy of the engine. The sender bursts,
// the receiver stalls, and the registers are rewritten between phases.
// ----------------------------------------------------------------------------
module tb_rssi_pulse_width_capture_core import rpwc_pkg::*;;

	typedef struct packed {
		logic [3:0]  fn;
		logic [63:0] t;
		logic [7:0]  rssi;
		logic        lvl;
		logic [31:0] dur;
		logic        clip;
		logic        ovf;
		logic [31:0] ecode;
		logic [9:0]  idx;
	} cmd_t;

	typedef struct packed {
		logic        acc;
		logic [2:0]  st;
		logic [10:0] cnt;
		logic [15:0] pval;
		logic        trunc;
		logic [31:0] samples;
		logic [31:0] invalids;
		logic [31:0] shorts;
		logic [63:0] sig_start;
		logic [63:0] t_end;
		logic        first;
		logic [31:0] ecode;
	} status_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wen = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [18:0] cfg_wdata = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [151:0] s_tdata = '0;
	logic [3:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [295:0] m_tdata;

	rssi_pulse_width_capture_core dut (.*);

	initial forever #5 clk = ~clk;

	// engine copy
	logic [18:0] regs [8];
	logic [18:0] plan [8];
	logic [2:0] ph;
	logic [63:0] t_start, sig_start, t_end;
	logic [15:0] store [RPWC_CAPACITY];
	logic [10:0] cnt;
	logic cand_ok, cand_lvl, stab_lvl, elvl, elvl_ok, trunc_f, first_f;
	logic [63:0] cand_since, stab_since, last_t;
	logic [31:0] n_samp, n_inv, n_short, ecode_r;

	cmd_t pending_cmds[$];
	status_t expected_status[$];
	cmd_t cur_cmd;
	int errors = 0;
	int sent = 0;
	int unsigned cycles = 0;
	logic [63:0] now_us;

	function automatic logic [31:0] bump(logic [31:0] v);
		return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
	endfunction

	function automatic logic signed [8:0] thr();
		return $signed({plan[REG_THR][7], plan[REG_THR][7:0]});
	endfunction

	function automatic logic [18:0] reg_mask(reg_idx_t i);
		case (i)
			REG_THR:              return 19'hFF;
			REG_DEB, REG_MINEDGE: return 19'h3FF;
			REG_LONG, REG_GAP:    return 19'hFFFF;
			REG_MAXP:             return 19'h7FF;
			REG_EDGE:             return 19'h1;
			default:              return 19'h7FFFF;
		endcase
	endfunction

	function automatic void wipe();
		ph = ST_IDLE; t_start = 0; sig_start = 0; t_end = 0; cnt = 0;
		cand_ok = 0; cand_lvl = 0; cand_since = 0; stab_lvl = 0; stab_since = 0;
		last_t = 0; elvl = 0; elvl_ok = 0; n_samp = 0; n_inv = 0; n_short = 0;
		trunc_f = 0; first_f = 0; ecode_r = 0;
		foreach (plan[i]) plan[i] = 0;
	endfunction

	function automatic bit regs_valid();
		logic signed [7:0] th;
		th = regs[REG_THR][7:0];
		return th >= THR_MIN && th <= THR_MAX &&
			regs[REG_DEB] >= 20 && regs[REG_DEB] <= 1000 &&
			regs[REG_WAIT] >= 1000 && regs[REG_WAIT] <= 300000 &&
			regs[REG_LONG] >= 100 && regs[REG_LONG] <= 60000 &&
			regs[REG_GAP] >= 5000 && regs[REG_GAP] <= 60000 &&
			regs[REG_MAXP] >= 2 && regs[REG_MAXP] <= RPWC_CAPACITY &&
			regs[REG_MINEDGE] >= 1 && regs[REG_MINEDGE] <= 1000;
	endfunction

	function automatic bit full();
		return cnt >= plan[REG_MAXP] || cnt >= RPWC_CAPACITY;
	endfunction

	function automatic bit close_capture(logic [63:0] t, bit tr);
		if (ph != ST_CAPT || t < sig_start) return 0;
		ph = ST_DONE; t_end = t; trunc_f = trunc_f | tr;
		return 1;
	endfunction

	function automatic bit settle(logic lvl, logic [63:0] t);
		logic [63:0] d;
		if (ph == ST_WAIT) begin
			if (!lvl) return 0;
			ph = ST_CAPT; sig_start = cand_since; first_f = 1;
			stab_lvl = 1; stab_since = cand_since;
			return 1;
		end
		if (ph != ST_CAPT || lvl == stab_lvl || t < stab_since) return 0;
		if (plan[REG_EDGE][0]) begin
			stab_lvl = lvl; stab_since = cand_since;
			return 1;
		end
		d = cand_since - stab_since;
		if (d == 0) return 0;
		if (full()) return close_capture(cand_since, 1);
		if (d > 65535) trunc_f = 1;
		store[cnt] = (d > 65535) ? SAT16 : d[15:0];
		cnt++;
		stab_lvl = lvl; stab_since = cand_since;
		if (full()) return close_capture(cand_since, 1);
		return 1;
	endfunction

	function automatic bit watch_limits(logic [63:0] t);
		if (t == 0 || t < t_start) return 0;
		if (ph == ST_WAIT && t - t_start >= 64'(plan[REG_WAIT]) * 1000) begin
			ph = ST_TIMEOUT; t_end = t;
			return 1;
		end
		if (ph == ST_CAPT && !stab_lvl && t - stab_since >= plan[REG_GAP]) begin
			if (plan[REG_EDGE][0] && cnt == 0) begin
				ph = ST_TIMEOUT; t_end = t;
				return 1;
			end
			return close_capture(t, 0);
		end
		if (ph == ST_CAPT && t - sig_start >= 64'(plan[REG_LONG]) * 1000) begin
			ph = ST_LONG; t_end = t;
			return 1;
		end
		return 0;
	endfunction

	function automatic bit take_sample(logic [63:0] t, logic signed [7:0] r);
		logic lvl;
		bit ch;
		ch = 0;
		if (ph != ST_WAIT && ph != ST_CAPT) return 0;
		n_samp = bump(n_samp);
		if (t == 0 || t < t_start || t < last_t || r < RSSI_MIN || r > RSSI_MAX) begin
			n_inv = bump(n_inv);
			return 0;
		end
		last_t = t;
		lvl = $signed({r[7], r}) > thr();
		if (!cand_ok || lvl != cand_lvl) begin
			if (cand_ok && t - cand_since < plan[REG_DEB]) n_short = bump(n_short);
			cand_ok = 1; cand_lvl = lvl; cand_since = t;
			return watch_limits(t);
		end
		if (t - cand_since >= plan[REG_DEB] && (ph == ST_WAIT || cand_lvl != stab_lvl))
			ch = settle(cand_lvl, t);
		return watch_limits(t) || ch;
	endfunction

	function automatic bit take_edge(cmd_t c);
		bit cl;
		if (!plan[REG_EDGE][0] || ph != ST_CAPT || !elvl_ok || c.t < sig_start ||
			c.dur == 0) begin
			n_inv = bump(n_inv);
			return 0;
		end
		if (c.lvl == elvl) return 0;
		if (c.dur < plan[REG_MINEDGE]) begin
			n_short = bump(n_short);
			return 0;
		end
		if (full()) return close_capture(c.t, 1);
		cl = c.clip || c.dur > 65535;
		store[cnt] = cl ? SAT16 : c.dur[15:0];
		cnt++;
		trunc_f = trunc_f | cl; elvl = c.lvl;
		if (full()) return close_capture(c.t, 1);
		return 1;
	endfunction

	function automatic status_t predict_status(cmd_t c);
		status_t s;
		bit acc;
		logic [15:0] pv;
		acc = 0; pv = 0;
		case (c.fn)
			FN_START: if (ph == ST_IDLE && c.t != 0 && regs_valid()) begin
				foreach (plan[i]) plan[i] = regs[i];
				n_samp = 0; n_inv = 0; n_short = 0; trunc_f = 0; first_f = 0; ecode_r = 0;
				sig_start = 0; t_end = 0; ph = ST_WAIT; t_start = c.t; cnt = 0;
				cand_ok = 0; cand_since = 0; stab_since = 0; last_t = 0;
				elvl = 0; elvl_ok = 0; acc = 1;
			end
			FN_SAMPLE: acc = take_sample(c.t, c.rssi);
			FN_ARM: if (plan[REG_EDGE][0] && ph == ST_CAPT && c.t >= sig_start) begin
				if (!elvl_ok) first_f = c.lvl;
				elvl = c.lvl; elvl_ok = 1; acc = 1;
			end
			FN_EDGE: acc = take_edge(c);
			FN_XEND: if (plan[REG_EDGE][0] && ph == ST_CAPT && c.t >= sig_start && c.ovf)
				acc = close_capture(c.t, 1);
			FN_CANCEL, FN_FAIL: if ((ph == ST_WAIT || ph == ST_CAPT) && c.t >= t_start) begin
				ph = (c.fn == FN_CANCEL) ? ST_CANCEL : ST_FAIL;
				t_end = c.t;
				if (c.fn == FN_FAIL) ecode_r = c.ecode;
				acc = 1;
			end
			FN_READ: if (c.idx < cnt) begin
				pv = store[c.idx]; acc = 1;
			end
			FN_TICK: acc = watch_limits(c.t);
			FN_CLEAR: begin
				wipe(); acc = 1;
			end
			default: ;
		endcase
		s = '{acc, ph, cnt, pv, trunc_f, n_samp, n_inv, n_short, sig_start, t_end,
			first_f, ecode_r};
		return s;
	endfunction

	task automatic chk(string name, logic [63:0] e, logic [63:0] g);
		if (g !== e) begin
			$error("%s exp %0h got %0h", name, e, g);
			errors++;
		end
	endtask

	// driver
	int gap = 0, burst = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (!s_tvalid || s_tready) begin
				if (s_tvalid) begin
					expected_status.push_back(predict_status(cur_cmd));
					sent++;
				end
				if (gap > 0) begin
					gap--;
					s_tvalid <= 1'b0;
				end else if (pending_cmds.size() > 0) begin
					cmd_t c;
					c = pending_cmds.pop_front();
					cur_cmd = c;
					s_tuser <= c.fn;
					s_tdata <= {3'b0, c.idx, c.ecode, c.ovf, c.clip, c.dur, c.lvl, c.rssi, c.t};
					s_tvalid <= 1'b1;
					if (burst > 0) burst--;
					else begin
						burst = $urandom_range(0, 30);
						gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end
				end else s_tvalid <= 1'b0;
			end
		end
	end

	// monitor
	int stall_phase = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				status_t got, exp_s;
				got = '{m_tdata[0], m_tdata[3:1], m_tdata[14:4], m_tdata[30:15], m_tdata[31],
					m_tdata[63:32], m_tdata[95:64], m_tdata[127:96], m_tdata[191:128],
					m_tdata[255:192], m_tdata[256], m_tdata[288:257]};
				if (expected_status.size() == 0) begin
					$error("status item with nothing expected");
					errors++;
				end else begin
					exp_s = expected_status.pop_front();
					chk("accepted", 64'(exp_s.acc), 64'(got.acc));
					chk("capture_state", 64'(exp_s.st), 64'(got.st));
					chk("pulse_count", 64'(exp_s.cnt), 64'(got.cnt));
					chk("pulse_value", 64'(exp_s.pval), 64'(got.pval));
					chk("truncated", 64'(exp_s.trunc), 64'(got.trunc));
					chk("sample_total", 64'(exp_s.samples), 64'(got.samples));
					chk("invalid_total", 64'(exp_s.invalids), 64'(got.invalids));
					chk("short_total", 64'(exp_s.shorts), 64'(got.shorts));
					chk("signal_start_us", exp_s.sig_start, got.sig_start);
					chk("end_time_us", exp_s.t_end, got.t_end);
					chk("first_level", 64'(exp_s.first), 64'(got.first));
					chk("error_code_out", 64'(exp_s.ecode), 64'(got.ecode));
				end
			end
			stall_phase = (stall_phase + 1) % 97;
			if (stall_phase < 20) m_tready <= 1'b1;
			else if (stall_phase < 30) m_tready <= (stall_phase % 3 != 0);
			else m_tready <= ($urandom_range(0, 3) != 0);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > 400000) begin
			$display("tb_rssi_pulse_width_capture_core: done, errors");
			$finish;
		end
	end

	function automatic cmd_t mk(logic [3:0] fn, logic [63:0] t);
		cmd_t c;
		c = '{fn, t, 8'($urandom), 1'($urandom), $urandom, 1'($urandom), 1'($urandom),
			$urandom, 10'($urandom)};
		return c;
	endfunction

	task automatic push(cmd_t c);
		pending_cmds.push_back(c);
	endtask

	task automatic push_sample(logic signed [7:0] r);
		cmd_t c;
		c = mk(FN_SAMPLE, now_us);
		c.rssi = r;
		push(c);
	endtask

	task automatic wr(reg_idx_t i, logic [18:0] v);
		@(posedge clk);
		cfg_wen <= 1'b1; cfg_index <= i; cfg_wdata <= v;
		regs[i] = v & reg_mask(i);
		@(posedge clk);
		cfg_wen <= 1'b0;
	endtask

	task automatic drain();
		while (pending_cmds.size() > 0 || s_tvalid || expected_status.size() > 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	// a session: clear, start, then samples or edges, with reads, ticks and stray commands mixed in
	task automatic session(int n, bit edges);
		cmd_t c;
		push(mk(FN_CLEAR, now_us));
		now_us += $urandom_range(1, 50);
		push(mk(FN_START, now_us));
		for (int k = 0; k < n; k++) begin
			int r;
			r = $urandom_range(0, 99);
			now_us += ($urandom_range(0, 7) == 0) ? $urandom_range(0, 70000)
				: $urandom_range(0, 400);
			if (r < 55 || (!edges && r < 85)) push_sample(($urandom_range(0, 1))
				? -8'sd20 - 8'($urandom_range(0, 10))
				: -8'sd120 + 8'($urandom_range(0, 5)));
			else if (r < 85) begin
				c = mk(($urandom_range(0, 5) == 0) ? FN_ARM : FN_EDGE, now_us);
				c.dur = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 1200);
				c.clip = ($urandom_range(0, 9) == 0);
				push(c);
			end else if (r < 93) push(mk(FN_READ, now_us));
			else if (r < 97) push(mk(FN_TICK, now_us));
			else begin
				c = mk(4'($urandom_range(0, 15)), ($urandom_range(0, 1)) ? now_us : $urandom);
				if (c.fn == FN_XEND) c.ovf = $urandom_range(0, 3) == 0;
				push(c);
			end
		end
		for (int k = 0; k < 3; k++) push(mk(FN_READ, now_us));
	endtask

	initial begin
		cmd_t c;
		regs = '{19'hA6, 100, 30000, 10000, 20000, 1024, 50, 0};
		wipe();
		now_us = 1000;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extremes, every command, refused starts, out of range reads
		push(mk(FN_READ, 0));
		push(mk(FN_START, 0));
		push(mk(4'd15, 5));
		push(mk(4'd10, 5));
		push(mk(FN_START, now_us));
		push(mk(FN_START, now_us));
		now_us += 10; push_sample(-8'sd128);
		now_us += 10; push_sample(8'sd127);
		now_us += 10; push_sample(RSSI_MIN);
		now_us += 10; push_sample(RSSI_MAX);
		now_us += 200; push_sample(RSSI_MAX);
		now_us += 300; push_sample(RSSI_MIN);
		now_us += 400; push_sample(RSSI_MIN);
		now_us += 100; push_sample(RSSI_MAX);
		now_us += 300; push_sample(RSSI_MAX);
		push(mk(FN_READ, now_us));
		c = mk(FN_READ, now_us); c.idx = 10'h3FF; push(c);
		c = mk(FN_SAMPLE, 0); c.rssi = -8'sd50; push(c);
		push(mk(FN_ARM, now_us));
		push(mk(FN_EDGE, now_us));
		push(mk(FN_XEND, now_us));
		c = mk(FN_FAIL, 64'hFFFF_FFFF_FFFF_FFFF); c.ecode = 32'h8000_0000; push(c);
		push(mk(FN_CANCEL, now_us));
		push(mk(FN_TICK, now_us));
		push(mk(FN_CLEAR, now_us));
		drain();

		// envelope mode at the extreme settings
		wr(REG_THR, 19'(-110 & 8'hFF)); wr(REG_DEB, 20); wr(REG_WAIT, 1000);
		wr(REG_LONG, 100); wr(REG_GAP, 5000); wr(REG_MAXP, 2); wr(REG_MINEDGE, 1);
		wr(REG_EDGE, 0);
		for (int s = 0; s < 3; s++) session(25, 0);
		drain();

		// waiting out the gap, then a late tick to force a time limit
		wr(REG_THR, 19'(-30 & 8'hFF)); wr(REG_DEB, 1000); wr(REG_WAIT, 300000);
		wr(REG_LONG, 60000); wr(REG_GAP, 60000); wr(REG_MAXP, 1024);
		for (int s = 0; s < 3; s++) session(30, 0);
		now_us += 64'd400_000_000; push(mk(FN_TICK, now_us));
		drain();

		// edge mode
		wr(REG_EDGE, 1); wr(REG_MINEDGE, 1000); wr(REG_DEB, 20); wr(REG_MAXP, 6);
		wr(REG_THR, 19'(-90 & 8'hFF)); wr(REG_GAP, 5000);
		for (int s = 0; s < 4; s++) session(35, 1);
		drain();

		// an illegal plan that start refuses, then a wide random mix
		wr(REG_MAXP, 19'h7FFFF);
		push(mk(FN_START, now_us));
		drain();
		wr(REG_MAXP, 3); wr(REG_MINEDGE, 30); wr(REG_WAIT, 2000); wr(REG_LONG, 5000);
		for (int s = 0; s < 3; s++) session(30, $urandom_range(0, 1));
		drain();
		wr(REG_EDGE, 0); wr(REG_MAXP, 5);
		for (int s = 0; s < 2; s++) session(25, 0);
		drain();

		if (errors == 0) $display("tb_rssi_pulse_width_capture_core: done, clean");
		else $display("tb_rssi_pulse_width_capture_core: done, errors");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+sv
sv/rpwc_pkg.sv
sv/rpwc_store.sv
sv/rpwc_ctrl.sv
sv/rssi_pulse_width_capture_core.sv
sim/tb_rssi_pulse_width_capture_core.sv
